[sv/hflr_pkg.sv]
// ----------------------------------------------------------------------------
// hflr_pkg
// Shared types, codes and character helpers for the hex float literal
// recognizer.
// ----------------------------------------------------------------------------
package hflr_pkg;

   localparam int unsigned CHAR_W    = 8;
   localparam int unsigned VERDICT_W = 3;

   typedef enum logic [3:0] {
      ST_START  = 4'd0,
      ST_ZERO   = 4'd1,
      ST_PREFIX = 4'd2,
      ST_POINT  = 4'd3,
      ST_WHOLE  = 4'd4,
      ST_FRACT  = 4'd5,
      ST_EXP    = 4'd6,
      ST_SIGN   = 4'd7,
      ST_DIGIT  = 4'd8,
      ST_SUF_F  = 4'd9,
      ST_SUF_L  = 4'd10,
      ST_FAIL   = 4'd11
   } parse_state_type;

   typedef logic [VERDICT_W-1:0] verdict_type;

   localparam verdict_type V_PENDING = 3'd0;
   localparam verdict_type V_NOMATCH = 3'd1;
   localparam verdict_type V_FLOAT   = 3'd2;
   localparam verdict_type V_DOUBLE  = 3'd3;
   localparam verdict_type V_LDOUBLE = 3'd4;

   localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
   localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
   localparam logic [CHAR_W-1:0] CH_X     = 8'h58;
   localparam logic [CHAR_W-1:0] CH_P     = 8'h50;
   localparam logic [CHAR_W-1:0] CH_F     = 8'h46;
   localparam logic [CHAR_W-1:0] CH_L     = 8'h4C;
   localparam logic [CHAR_W-1:0] CH_POINT = 8'h2E;
   localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
   localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;

   function automatic logic [CHAR_W-1:0] upcase(input logic [CHAR_W-1:0] c);
      if (c >= 8'h61 && c <= 8'h7A) begin
         return c - 8'h20;
      end
      return c;
   endfunction

   function automatic logic is_dec(input logic [CHAR_W-1:0] c);
      return (c >= 8'h30) && (c <= 8'h39);
   endfunction

   // expects an upper-cased character
   function automatic logic is_hex(input logic [CHAR_W-1:0] c);
      return is_dec(c) || ((c >= 8'h41) && (c <= 8'h46));
   endfunction

endpackage

[sv/hex_float_literal_recognizer_top.sv]
// Each accepted request passes through the input register and then the result register before its response.
// Throughput: one character per cycle while the response side does not stall; the parse state advances as each
// character leaves the input register for the result register.
// Reset: synchronous, active high; empties both registers and returns the
// recognizer to its start state.
// ----------------------------------------------------------------------------
// hex_float_literal_recognizer_top
// Streams characters through a recognizer for C hexadecimal floating
// literals; each character gives one response, final on the terminator.
// ----------------------------------------------------------------------------
module hex_float_literal_recognizer_top (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] ch
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [2:0] verdict, [7:3] zero
   output logic       rsp_tlast    // done_res
);
   import hflr_pkg::*;

   logic              in_valid_ff;
   logic [CHAR_W-1:0] in_ch_ff;
   logic              out_valid_ff;
   verdict_type       out_verdict_ff;
   logic              out_done_ff;

   logic              out_free;
   logic              in_move;
   verdict_type       verdict;
   logic              done_res;

   assign out_free   = !out_valid_ff || rsp_tready;
   assign in_move    = in_valid_ff && out_free;
   assign req_tready = !in_valid_ff || out_free;

   hflr_parse u_parse (
      .clock    (clock),
      .reset    (reset),
      .step     (in_move),
      .ch       (in_ch_ff),
      .verdict  (verdict),
      .done_res (done_res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_ch_ff <= req_tdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (in_move) begin
         out_verdict_ff <= verdict;
         out_done_ff    <= done_res;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(8 - VERDICT_W){1'b0}}, out_verdict_ff};
   assign rsp_tlast  = out_done_ff;

endmodule

[sv/hflr_parse.sv]
// ----------------------------------------------------------------------------
// hflr_parse
// Recognizer state machine: holds the parse position, steps it by one
// character and gives the verdict for the character presented.
// ----------------------------------------------------------------------------
module hflr_parse (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        step,
   input  logic [hflr_pkg::CHAR_W-1:0] ch,
   output hflr_pkg::verdict_type       verdict,
   output logic                        done_res
);
   import hflr_pkg::*;

   parse_state_type        parse_state_ff;
   parse_state_type        parse_state_in;
   logic [CHAR_W-1:0]      uc;

   assign uc = upcase(ch);

   always_ff @(posedge clock) begin
      if (reset) begin
         parse_state_ff <= ST_START;
      end else if (step) begin
         parse_state_ff <= parse_state_in;
      end
   end

   // next state
   always_comb begin
      parse_state_in = ST_FAIL;
      if (ch == CH_NUL) begin
         parse_state_in = ST_START;
      end else begin
         unique case (parse_state_ff)
            ST_START: begin
               parse_state_in = (uc == CH_ZERO) ? ST_ZERO : ST_FAIL;
            end
            ST_ZERO: begin
               parse_state_in = (uc == CH_X) ? ST_PREFIX : ST_FAIL;
            end
            ST_PREFIX: begin
               if (uc == CH_POINT)  parse_state_in = ST_POINT;
               else if (is_hex(uc)) parse_state_in = ST_WHOLE;
            end
            ST_POINT: begin
               if (is_hex(uc)) parse_state_in = ST_FRACT;
            end
            ST_WHOLE: begin
               if (uc == CH_POINT)  parse_state_in = ST_FRACT;
               else if (uc == CH_P) parse_state_in = ST_EXP;
               else if (is_hex(uc)) parse_state_in = ST_WHOLE;
            end
            ST_FRACT: begin
               if (uc == CH_P)      parse_state_in = ST_EXP;
               else if (is_hex(uc)) parse_state_in = ST_FRACT;
            end
            ST_EXP: begin
               if (uc == CH_PLUS || uc == CH_MINUS) parse_state_in = ST_SIGN;
               else if (is_dec(uc))                 parse_state_in = ST_DIGIT;
            end
            ST_SIGN: begin
               if (is_dec(uc)) parse_state_in = ST_DIGIT;
            end
            ST_DIGIT: begin
               if (is_dec(uc))      parse_state_in = ST_DIGIT;
               else if (uc == CH_F) parse_state_in = ST_SUF_F;
               else if (uc == CH_L) parse_state_in = ST_SUF_L;
            end
            default: begin
               parse_state_in = ST_FAIL;
            end
         endcase
      end
   end

   // verdict, final only on the terminator
   always_comb begin
      verdict  = V_PENDING;
      done_res = 1'b0;
      if (ch == CH_NUL) begin
         done_res = 1'b1;
         unique case (parse_state_ff)
            ST_DIGIT: verdict = V_DOUBLE;
            ST_SUF_F: verdict = V_FLOAT;
            ST_SUF_L: verdict = V_LDOUBLE;
            default:  verdict = V_NOMATCH;
         endcase
      end
   end

endmodule

[sv/hflr_checker.sv]
// ----------------------------------------------------------------------------
// hflr_checker
// Port-level checks for the recognizer, bound to the top level.
// ----------------------------------------------------------------------------
module hflr_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_tvalid,
   input logic       req_tready,
   input logic [7:0] req_tdata,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic       rsp_tlast
);

   // a final verdict is one of the four outcomes
   a_final_verdict: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |->
         (rsp_tdata == 8'd1 || rsp_tdata == 8'd2 || rsp_tdata == 8'd3 ||
          rsp_tdata == 8'd4))
      else $error("final verdict out of range");

   // characters before the terminator stay pending
   a_pending: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> rsp_tdata == 8'd0)
      else $error("verdict given before terminator");

   // a stalled response holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=>
         rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled response changed");

   // nothing comes out the cycle after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   // a terminator accepted while no response is valid reaches the output through the input and result registers
   a_latency: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && !rsp_tvalid && req_tdata == 8'd0 |=>
         ##1 rsp_tvalid)
      else $error("response missing after accepted transaction");

endmodule

bind hex_float_literal_recognizer_top hflr_checker u_hflr_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

[verif/hex_float_literal_recognizer_top_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hex_float_literal_recognizer_top_tb
// Streams zero-terminated character strings into the recognizer and checks
// each response against a cycle-free scan of the same characters. Strings
// are mostly well-formed hex float literals with random content, plus
// corrupted and random ones. Both stream sides idle at random, and the
// response side holds off once for a long stretch.
// ----------------------------------------------------------------------------
module hex_float_literal_recognizer_top_tb;
   import hflr_pkg::*;

   typedef logic [CHAR_W-1:0] char_type;

   typedef struct packed {
      verdict_type verdict;
      logic        done;
   } verdict_result_type;

   logic       clock      = 1'b0;
   logic       reset      = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata  = '0;
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;
   logic       rsp_tlast;

   char_type           char_queue[$];
   verdict_result_type verdict_queue[$];
   parse_state_type    scan_state = ST_START;
   int unsigned        snd_idle_pct = 22;
   int unsigned        rcv_idle_pct = 81;
   int unsigned        error_count  = 0;
   int unsigned        stall_left   = 0;
   logic               long_stall_req  = 1'b0;
   logic               long_stall_done = 1'b0;

   hex_float_literal_recognizer_top u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   initial begin
      #2000000;
      $display("FAILED: results differ");
      $finish;
   end

   // ---------------------------------------------------------------- scanner

   function automatic char_type fold_case(input char_type c);
      return (c inside {[8'h61:8'h7A]}) ? (c & 8'hDF) : c;
   endfunction

   function automatic logic dec_char(input char_type c);
      return c inside {[8'h30:8'h39]};
   endfunction

   function automatic logic hex_char(input char_type c);
      return dec_char(c) || (c inside {[8'h41:8'h46]});
   endfunction

   function automatic parse_state_type advance_scan(input parse_state_type s,
                                                    input char_type raw);
      char_type c;
      c = fold_case(raw);
      case (s)
         ST_START:  return (c == CH_ZERO) ? ST_ZERO : ST_FAIL;
         ST_ZERO:   return (c == CH_X) ? ST_PREFIX : ST_FAIL;
         ST_PREFIX: begin
            if (c == CH_POINT) return ST_POINT;
            return hex_char(c) ? ST_WHOLE : ST_FAIL;
         end
         ST_POINT:  return hex_char(c) ? ST_FRACT : ST_FAIL;
         ST_WHOLE: begin
            if (c == CH_POINT) return ST_FRACT;
            if (c == CH_P) return ST_EXP;
            return hex_char(c) ? ST_WHOLE : ST_FAIL;
         end
         ST_FRACT: begin
            if (c == CH_P) return ST_EXP;
            return hex_char(c) ? ST_FRACT : ST_FAIL;
         end
         ST_EXP: begin
            if (c == CH_PLUS || c == CH_MINUS) return ST_SIGN;
            return dec_char(c) ? ST_DIGIT : ST_FAIL;
         end
         ST_SIGN:   return dec_char(c) ? ST_DIGIT : ST_FAIL;
         ST_DIGIT: begin
            if (dec_char(c)) return ST_DIGIT;
            if (c == CH_F) return ST_SUF_F;
            if (c == CH_L) return ST_SUF_L;
            return ST_FAIL;
         end
         default:   return ST_FAIL;
      endcase
   endfunction

   task automatic scan_char(input char_type c);
      verdict_result_type res;
      if (c == CH_NUL) begin
         case (scan_state)
            ST_DIGIT: res.verdict = V_DOUBLE;
            ST_SUF_F: res.verdict = V_FLOAT;
            ST_SUF_L: res.verdict = V_LDOUBLE;
            default:  res.verdict = V_NOMATCH;
         endcase
         res.done   = 1'b1;
         scan_state = ST_START;
      end else begin
         res.verdict = V_PENDING;
         res.done    = 1'b0;
         scan_state  = advance_scan(scan_state, c);
      end
      verdict_queue.push_back(res);
   endtask

   // ---------------------------------------------------------------- stimulus

   function automatic char_type mixed_case(input char_type c);
      if ((c inside {[8'h41:8'h5A]}) && $urandom_range(0, 1) == 1) begin
         return c | 8'h20;
      end
      return c;
   endfunction

   function automatic char_type random_hex_digit();
      string digits;
      digits = "0123456789ABCDEF";
      return mixed_case(digits[$urandom_range(0, 15)]);
   endfunction

   task automatic push_literal(input string s);
      foreach (s[i]) char_queue.push_back(s[i]);
      char_queue.push_back(CH_NUL);
   endtask

   task automatic queue_random_string();
      char_type    lit[$];
      int unsigned kind;
      int unsigned form;
      int unsigned n;
      kind = $urandom_range(0, 99);
      if (kind < 10) begin
         // plain noise
         n = $urandom_range(0, 8);
         repeat (n) lit.push_back(char_type'($urandom_range(1, 255)));
      end else begin
         lit.push_back(CH_ZERO);
         lit.push_back(mixed_case(CH_X));
         form = $urandom_range(0, 2);
         if (form != 2) begin
            repeat ($urandom_range(1, 4)) lit.push_back(random_hex_digit());
         end
         if (form != 0) begin
            lit.push_back(CH_POINT);
            repeat ($urandom_range((form == 2) ? 1 : 0, 4)) lit.push_back(random_hex_digit());
         end
         lit.push_back(mixed_case(CH_P));
         n = $urandom_range(0, 2);
         if (n == 1) lit.push_back(CH_PLUS);
         else if (n == 2) lit.push_back(CH_MINUS);
         repeat ($urandom_range(1, 3)) lit.push_back(char_type'(CH_ZERO + $urandom_range(0, 9)));
         n = $urandom_range(0, 2);
         if (n == 1) lit.push_back(mixed_case(CH_F));
         else if (n == 2) lit.push_back(mixed_case(CH_L));
         // break some of them: overwrite a byte, cut short, or trail junk
         if (kind < 18) begin
            lit[$urandom_range(0, lit.size() - 1)] = char_type'($urandom_range(1, 255));
         end else if (kind < 24) begin
            n = $urandom_range(0, lit.size() - 1);
            while (lit.size() > n) void'(lit.pop_back());
         end else if (kind < 28) begin
            lit.push_back(char_type'($urandom_range(1, 255)));
         end
      end
      foreach (lit[i]) char_queue.push_back(lit[i]);
      char_queue.push_back(CH_NUL);
   endtask

   // ---------------------------------------------------------------- driver

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         scan_state = ST_START;
      end else begin
         if (req_tvalid && req_tready) begin
            scan_char(req_tdata);
         end
         if (!req_tvalid || req_tready) begin
            if (char_queue.size() > 0 && $urandom_range(0, 99) >= snd_idle_pct) begin
               req_tvalid <= 1'b1;
               req_tdata  <= char_queue.pop_front();
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------- monitor

   always @(posedge clock) begin
      verdict_result_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (verdict_queue.size() == 0) begin
               $error("verdict: no transaction expected, got %0d", rsp_tdata[2:0]);
               error_count++;
            end else begin
               want = verdict_queue.pop_front();
               if (rsp_tdata[2:0] !== want.verdict) begin
                  $error("verdict: expected %0d, got %0d", want.verdict, rsp_tdata[2:0]);
                  error_count++;
               end
               if (rsp_tdata[7:3] !== 5'd0) begin
                  $error("pad: expected 0, got %0d", rsp_tdata[7:3]);
                  error_count++;
               end
               if (rsp_tlast !== want.done) begin
                  $error("done_res: expected %0d, got %0d", want.done, rsp_tlast);
                  error_count++;
               end
            end
         end
         if (long_stall_req && !long_stall_done) begin
            stall_left      = 150;
            long_stall_done = 1'b1;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(0, 99) >= rcv_idle_pct);
         end
      end
   end

   // ---------------------------------------------------------------- sequence

   initial begin
      int unsigned phase;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      push_literal("");
      push_literal("0X.fP+9F");
      push_literal("0xa.p-1l");
      push_literal("0x1p0");
      push_literal("0x1p");
      push_literal("0x7p1Fe");

      for (phase = 0; phase < 3; phase++) begin
         if (phase == 1) begin
            snd_idle_pct = 81;
            rcv_idle_pct = 22;
         end else if (phase == 2) begin
            snd_idle_pct   = 0;
            rcv_idle_pct   = 0;
            long_stall_req = 1'b1;
         end
         while (char_queue.size() < 660) queue_random_string();
         while (char_queue.size() != 0 || req_tvalid || verdict_queue.size() != 0) begin
            @(negedge clock);
         end
      end

      repeat (10) @(negedge clock);
      if (error_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

[hex_float_literal_recognizer_top.f]
sv/hflr_pkg.sv
sv/hflr_parse.sv
sv/hex_float_literal_recognizer_top.sv
sv/hflr_checker.sv
verif/hex_float_literal_recognizer_top_tb.sv
